// File: hdl/fcrms_pkg.sv
package fcrms_pkg;

    localparam int WORD_W      = 16;
    localparam int MAG_W       = 24;
    localparam int PROD_W      = 2 * MAG_W;
    localparam int SUM_W       = 63;
    localparam int RES_W       = 24;
    localparam int NUM_OUT     = 4;
    localparam int CH_W        = 3;
    localparam int TAG_SEL_W   = 5;
    localparam int CFG_W       = 5;
    localparam int ROOT_W      = 32;
    localparam int RAD_W       = 2 * ROOT_W;
    localparam int REM_W       = ROOT_W + 2;
    localparam int PDATA_W     = 32;
    localparam int PADDR_W     = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [CFG_W-1:0]  BLOCK_LEN_RESET = 5'd11;
    localparam logic [SUM_W-1:0]  SUM_MAX         = '1;
    localparam logic [ROOT_W-1:0] RMS_MAX         = 32'd8388608;

    localparam logic [PADDR_W-3:0] REG_BLOCK_LEN = 1'b0;

    typedef struct packed {
        logic [WORD_W-1:0] word_high;
        logic [WORD_W-1:0] word_low;
    } in_item_t;

    typedef struct packed {
        logic [RES_W-1:0] rms_ch3;
        logic [RES_W-1:0] rms_ch2;
        logic [RES_W-1:0] rms_ch1;
        logic [RES_W-1:0] rms_ch0;
    } out_item_t;

    typedef struct packed {
        logic             tag_ok;
        logic [CH_W-1:0]  ch;
        logic [MAG_W-1:0] mag;
    } q_entry_t;

    typedef struct packed {
        logic             start;
        logic [RAD_W-1:0] radicand;
    } sq_req_t;

    typedef struct packed {
        logic              done;
        logic [ROOT_W-1:0] root;
    } sq_rsp_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL,
        B_ACC,
        B_ROOT_GO,
        B_ROOT_WAIT,
        B_OUT
    } back_state_t;

endpackage

// File: hdl/four_channel_block_rms_top.sv
// An item written to the queue can be popped in the next cycle; the back end then takes it
// through fetch, square and accumulate, and fetches the next item only after accumulating it.
// An item that completes a block then runs the iterative square root once per reported channel
// (two bits per cycle over a 64-bit radicand) and loads the result once the output register is free.
// The front accepts while the four-entry queue has room, also during the root phase.
// Synchronous active-low reset clears sums, counts, queue and handshakes; block length (log2) is 11.
module four_channel_block_rms_top #(
    parameter int NUM_CHANNELS   = 4,
    parameter int SAMPLE_BITS    = 24,
    parameter int MAX_BLOCK_LOG2 = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  fcrms_pkg::in_item_t                s_item,
    output logic                               m_valid,
    input  logic                               m_ready,
    output fcrms_pkg::out_item_t               m_item,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [fcrms_pkg::PADDR_W-1:0]      paddr,
    input  logic [fcrms_pkg::PDATA_W-1:0]      pwdata,
    output logic [fcrms_pkg::PDATA_W-1:0]      prdata,
    output logic                               pready
);
    import fcrms_pkg::*;

    localparam int L_W = $clog2(MAX_BLOCK_LOG2 + 1);

    logic [CFG_W-1:0] block_len_reg, block_len_next;
    logic [L_W-1:0]   l_eff;
    logic             q_full;
    logic             q_push;
    q_entry_t         push_entry;
    logic             q_pop;
    logic             q_valid;
    q_entry_t         pop_entry;
    sq_req_t          sq_req;
    sq_rsp_t          sq_rsp;

    always_comb begin
        pready         = 1'b1;
        block_len_next = block_len_reg;
        if (psel && penable && pwrite && paddr[PADDR_W-1:2] == REG_BLOCK_LEN) begin
            block_len_next = pwdata[CFG_W-1:0];
        end
        prdata = (paddr[PADDR_W-1:2] == REG_BLOCK_LEN) ? PDATA_W'(block_len_reg) : '0;
        l_eff  = (block_len_reg > CFG_W'(MAX_BLOCK_LOG2)) ? L_W'(MAX_BLOCK_LOG2)
                                                         : block_len_reg[L_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_len_reg <= BLOCK_LEN_RESET;
        end else begin
            block_len_reg <= block_len_next;
        end
    end

    fcrms_front #(
        .NUM_CHANNELS(NUM_CHANNELS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_item (s_item),
        .q_full (q_full),
        .q_push (q_push),
        .q_entry(push_entry)
    );

    fcrms_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_entry(push_entry),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_entry (pop_entry)
    );

    fcrms_isqrt u_isqrt (
        .aclk   (aclk),
        .aresetn(aresetn),
        .req    (sq_req),
        .rsp    (sq_rsp)
    );

    fcrms_back #(
        .NUM_CHANNELS  (NUM_CHANNELS),
        .MAX_BLOCK_LOG2(MAX_BLOCK_LOG2),
        .L_W           (L_W)
    ) u_back (
        .aclk   (aclk),
        .aresetn(aresetn),
        .q_valid(q_valid),
        .q_entry(pop_entry),
        .q_pop  (q_pop),
        .l_eff  (l_eff),
        .sq_req (sq_req),
        .sq_rsp (sq_rsp),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_item (m_item)
    );

endmodule

// File: hdl/fcrms_front.sv
module fcrms_front #(
    parameter int NUM_CHANNELS = 4,
    parameter int SAMPLE_BITS  = 24
) (
    input  logic                s_valid,
    output logic                s_ready,
    input  fcrms_pkg::in_item_t s_item,
    input  logic                q_full,
    output logic                q_push,
    output fcrms_pkg::q_entry_t q_entry
);
    import fcrms_pkg::*;

    localparam logic [MAG_W:0]   SPAN = (MAG_W + 1)'(1) << SAMPLE_BITS;
    localparam logic [MAG_W-1:0] MASK = MAG_W'(SPAN - (MAG_W + 1)'(1));

    logic [7:0]       tag;
    logic [MAG_W-1:0] raw;
    logic [MAG_W:0]   neg;
    logic             sign;

    always_comb begin
        tag  = s_item.word_high[15:8];
        raw  = {s_item.word_high[7:0], s_item.word_low} & MASK;
        sign = raw[SAMPLE_BITS-1];
        neg  = SPAN - {1'b0, raw};

        q_entry.tag_ok = (tag[TAG_SEL_W-1:0] == '0) && (int'(tag[7:5]) < NUM_CHANNELS);
        q_entry.ch     = tag[7:5];
        q_entry.mag    = sign ? neg[MAG_W-1:0] : raw;

        s_ready = !q_full;
        q_push  = s_valid && !q_full;
    end

endmodule

// File: hdl/fcrms_queue.sv
module fcrms_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  fcrms_pkg::q_entry_t push_entry,
    output logic                full,
    input  logic                pop,
    output logic                pop_valid,
    output fcrms_pkg::q_entry_t pop_entry
);
    import fcrms_pkg::*;

    q_entry_t          slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   fill_reg, fill_next;

    always_comb begin
        full        = (fill_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
        pop_valid   = (fill_reg != '0);
        pop_entry   = slot_reg[rd_ptr_reg];
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// File: hdl/fcrms_isqrt.sv
module fcrms_isqrt (
    input  logic               aclk,
    input  logic               aresetn,
    input  fcrms_pkg::sq_req_t req,
    output fcrms_pkg::sq_rsp_t rsp
);
    import fcrms_pkg::*;

    localparam int ITER   = RAD_W / 2;
    localparam int ITER_W = $clog2(ITER);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [ITER_W-1:0] cnt_reg, cnt_next;
    logic [RAD_W-1:0]  rad_reg, rad_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;

    always_comb begin
        rem_sh    = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
        trial     = {root_reg, 2'b01};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = ITER_W'(ITER - 1);
            rad_next  = req.radicand;
            rem_next  = '0;
            root_next = '0;
        end else if (busy_reg) begin
            rad_next = rad_reg << 2;
            if (rem_sh >= trial) begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end else begin
                rem_next  = rem_sh;
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
        rsp.done = done_reg;
        rsp.root = root_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg  <= cnt_next;
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

endmodule

// File: hdl/fcrms_back.sv
module fcrms_back #(
    parameter int NUM_CHANNELS   = 4,
    parameter int MAX_BLOCK_LOG2 = 16,
    parameter int L_W            = $clog2(MAX_BLOCK_LOG2 + 1)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    input  fcrms_pkg::q_entry_t  q_entry,
    output logic                 q_pop,
    input  logic [L_W-1:0]       l_eff,
    output fcrms_pkg::sq_req_t   sq_req,
    input  fcrms_pkg::sq_rsp_t   sq_rsp,
    output logic                 m_valid,
    input  logic                 m_ready,
    output fcrms_pkg::out_item_t m_item
);
    import fcrms_pkg::*;

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CNT_W = MAX_BLOCK_LOG2 + 1;
    localparam int NOUT  = (NUM_CHANNELS < NUM_OUT) ? NUM_CHANNELS : NUM_OUT;

    back_state_t       state_reg, state_next;
    logic              ok_reg, ok_next;
    logic [IDX_W-1:0]  ch_reg, ch_next;
    logic [MAG_W-1:0]  mag_reg, mag_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [SUM_W-1:0]  sums_reg [NUM_CHANNELS];
    logic [SUM_W-1:0]  sums_next [NUM_CHANNELS];
    logic [CNT_W-1:0]  cnts_reg [NUM_CHANNELS];
    logic [CNT_W-1:0]  cnts_next [NUM_CHANNELS];
    logic [IDX_W-1:0]  k_reg, k_next;
    logic [RES_W-1:0]  res_reg [NUM_OUT];
    logic [RES_W-1:0]  res_next [NUM_OUT];
    logic              m_valid_reg, m_valid_next;
    out_item_t         m_item_reg, m_item_next;

    logic [CNT_W-1:0]  target;
    logic [IDX_W-1:0]  rd_idx;
    logic [SUM_W-1:0]  sum_sel;
    logic [SUM_W:0]    acc;
    logic [SUM_W-1:0]  sum_upd;
    logic [NUM_CHANNELS-1:0] hit;
    logic [CNT_W-1:0]  cnt_acc [NUM_CHANNELS];
    logic              all_full;
    logic [ROOT_W-1:0] root_clamped;

    always_comb begin
        target  = CNT_W'(1) << l_eff;
        rd_idx  = (state_reg == B_ACC) ? ch_reg : k_reg;
        sum_sel = sums_reg[rd_idx];
        acc     = {1'b0, sum_sel} + (SUM_W + 1)'(prod_reg);
        sum_upd = acc[SUM_W] ? SUM_MAX : acc[SUM_W-1:0];
        all_full = 1'b1;
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            hit[c]     = ok_reg && (ch_reg == IDX_W'(c)) && (cnts_reg[c] < target);
            cnt_acc[c] = cnts_reg[c] + CNT_W'(hit[c]);
            if (cnt_acc[c] < target) begin
                all_full = 1'b0;
            end
        end
        root_clamped = (sq_rsp.root > RMS_MAX) ? RMS_MAX : sq_rsp.root;

        state_next   = state_reg;
        ok_next      = ok_reg;
        ch_next      = ch_reg;
        mag_next     = mag_reg;
        prod_next    = prod_reg;
        sums_next    = sums_reg;
        cnts_next    = cnts_reg;
        k_next       = k_reg;
        res_next     = res_reg;
        m_item_next  = m_item_reg;
        m_valid_next = m_valid_reg && !m_ready;
        q_pop        = 1'b0;
        sq_req.start    = 1'b0;
        sq_req.radicand = RAD_W'(sum_sel) >> l_eff;

        case (state_reg)
            B_IDLE: begin
                if (q_valid) begin
                    q_pop      = 1'b1;
                    ok_next    = q_entry.tag_ok;
                    ch_next    = q_entry.ch[IDX_W-1:0];
                    mag_next   = q_entry.mag;
                    state_next = B_MUL;
                end
            end
            B_MUL: begin
                prod_next  = PROD_W'(mag_reg) * PROD_W'(mag_reg);
                state_next = B_ACC;
            end
            B_ACC: begin
                for (int c = 0; c < NUM_CHANNELS; c++) begin
                    if (hit[c]) begin
                        sums_next[c] = sum_upd;
                    end
                    cnts_next[c] = cnt_acc[c];
                end
                if (all_full) begin
                    k_next = '0;
                    for (int j = 0; j < NUM_OUT; j++) begin
                        res_next[j] = '0;
                    end
                    state_next = B_ROOT_GO;
                end else begin
                    state_next = B_IDLE;
                end
            end
            B_ROOT_GO: begin
                sq_req.start = 1'b1;
                state_next   = B_ROOT_WAIT;
            end
            B_ROOT_WAIT: begin
                if (sq_rsp.done) begin
                    for (int j = 0; j < NUM_OUT; j++) begin
                        if (j < NOUT && k_reg == IDX_W'(j)) begin
                            res_next[j] = root_clamped[RES_W-1:0];
                        end
                    end
                    if (k_reg == IDX_W'(NOUT - 1)) begin
                        state_next = B_OUT;
                    end else begin
                        k_next     = k_reg + 1'b1;
                        state_next = B_ROOT_GO;
                    end
                end
            end
            B_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next        = 1'b1;
                    m_item_next.rms_ch0 = res_reg[0];
                    m_item_next.rms_ch1 = res_reg[1];
                    m_item_next.rms_ch2 = res_reg[2];
                    m_item_next.rms_ch3 = res_reg[3];
                    for (int c = 0; c < NUM_CHANNELS; c++) begin
                        sums_next[c] = '0;
                        cnts_next[c] = '0;
                    end
                    state_next = B_IDLE;
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase

        m_valid = m_valid_reg;
        m_item  = m_item_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            m_valid_reg <= 1'b0;
            k_reg       <= '0;
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                sums_reg[c] <= '0;
                cnts_reg[c] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            k_reg       <= k_next;
            sums_reg    <= sums_next;
            cnts_reg    <= cnts_next;
        end
    end

    always_ff @(posedge aclk) begin
        ok_reg     <= ok_next;
        ch_reg     <= ch_next;
        mag_reg    <= mag_next;
        prod_reg   <= prod_next;
        res_reg    <= res_next;
        m_item_reg <= m_item_next;
    end

`ifndef SYNTHESIS
    a_root_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == B_ROOT_WAIT && sq_rsp.done)
        |=> (state_reg == B_ROOT_GO || state_reg == B_OUT))
        else $error("Root result did not advance the sequencer.");

    a_pop_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("Queue popped while empty.");

    a_clear_on_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == B_OUT && (!m_valid_reg || m_ready))
        |=> (m_valid_reg && cnts_reg[0] == '0 && sums_reg[0] == '0))
        else $error("Block state not cleared when the result was loaded.");

    a_root_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        sq_req.start |-> (state_reg == B_ROOT_GO))
        else $error("Square root started outside the root phase.");
`endif

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import fcrms_pkg::*;

    localparam int NUM_CH = 4;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 100;

    localparam logic [7:0] TAG_CH0 = 8'h00;
    localparam logic [7:0] TAG_CH1 = 8'h20;
    localparam logic [7:0] TAG_CH2 = 8'h40;
    localparam logic [7:0] TAG_CH3 = 8'h60;
    localparam logic [7:0] TAG_LOW_BITS = 8'h21;
    localparam logic [7:0] TAG_CH3_ODD = 8'h61;
    localparam logic [7:0] TAG_CH4 = 8'h80;
    localparam logic [7:0] TAG_TOP = 8'hE0;
    localparam logic [7:0] TAG_ALL_ONES = 8'hFF;
    localparam logic [7:0] CHANNEL_TAG [NUM_CH] = '{TAG_CH0, TAG_CH1, TAG_CH2, TAG_CH3};

    localparam logic [PADDR_W-1:0] BLOCK_LEN_ADDR = {REG_BLOCK_LEN, 2'b00};

    localparam out_item_t NO_RMS = '0;

    typedef struct packed {
        bit               is_cfg;
        logic [CFG_W-1:0] cfg;
        logic [7:0]       tag;
        logic [23:0]      value;
        bit               fixed_ok;
        out_item_t        fixed;
    } step_row_t;

    localparam int DIRECTED_ROWS = 30;
    localparam step_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{1'b1, 5'd0, TAG_CH0, 24'h000000, 1'b0, NO_RMS},
        '{1'b0, 5'd0, TAG_CH0, 24'h000000, 1'b0, NO_RMS},
        '{1'b0, 5'd0, TAG_CH1, 24'h7FFFFF, 1'b0, NO_RMS},
        '{1'b0, 5'd0, TAG_CH2, 24'h800000, 1'b0, NO_RMS},
        '{1'b0, 5'd0, TAG_CH3, 24'hFFFFFF, 1'b1,
          '{24'd1, 24'd8388608, 24'd8388607, 24'd0}},
        '{1'b0, 5'd0, TAG_CH0, 24'h000001, 1'b0, NO_RMS},
        '{1'b0, 5'd0, TAG_CH0, 24'h123456, 1'b0, NO_RMS},
        '{1'b0, 5'd0, TAG_LOW_BITS, 24'h0ABCDE, 1'b0, NO_RMS},
        '{1'b0, 5'd0, TAG_CH4, 24'h7FFFFF, 1'b0, NO_RMS},
        '{1'b0, 5'd0, TAG_TOP, 24'h800000, 1'b0, NO_RMS},
        '{1'b0, 5'd0, TAG_CH1, 24'h000002, 1'b0, NO_RMS},
        '{1'b0, 5'd0, TAG_CH2, 24'hFFFFFE, 1'b0, NO_RMS},
        '{1'b0, 5'd0, TAG_CH3, 24'h000003, 1'b1, '{24'd3, 24'd2, 24'd2, 24'd1}},
        '{1'b1, 5'd1, TAG_CH0, 24'h000000, 1'b0, NO_RMS},
        '{1'b0, 5'd0, TAG_CH0, 24'h000003, 1'b0, NO_RMS},
        '{1'b0, 5'd0, TAG_CH1, 24'hFFFF00, 1'b0, NO_RMS},
        '{1'b0, 5'd0, TAG_ALL_ONES, 24'hFFFFFF, 1'b0, NO_RMS},
        '{1'b0, 5'd0, TAG_CH2, 24'h7FFFFF, 1'b0, NO_RMS},
        '{1'b0, 5'd0, TAG_CH3, 24'h000010, 1'b0, NO_RMS},
        '{1'b0, 5'd0, TAG_CH0, 24'h000004, 1'b0, NO_RMS},
        '{1'b0, 5'd0, TAG_CH1, 24'h000100, 1'b0, NO_RMS},
        '{1'b0, 5'd0, TAG_CH2, 24'h800001, 1'b0, NO_RMS},
        '{1'b0, 5'd0, TAG_CH3, 24'hFFFFF0, 1'b0, NO_RMS},
        '{1'b1, 5'd2, TAG_CH0, 24'h000000, 1'b0, NO_RMS},
        '{1'b0, 5'd0, TAG_CH0, 24'h400000, 1'b0, NO_RMS},
        '{1'b0, 5'd0, TAG_CH1, 24'hC00000, 1'b0, NO_RMS},
        '{1'b0, 5'd0, TAG_CH2, 24'h000007, 1'b0, NO_RMS},
        '{1'b0, 5'd0, TAG_CH3, 24'hFFFFF9, 1'b0, NO_RMS},
        '{1'b1, 5'd0, TAG_CH0, 24'h000000, 1'b0, NO_RMS},
        '{1'b0, 5'd0, TAG_CH3_ODD, 24'h000000, 1'b0, NO_RMS}
    };

    localparam int PHASES = 10;
    localparam logic [CFG_W-1:0] PHASE_LOG2 [PHASES] = '{
        5'd0, 5'd3, 5'd16, 5'd1, 5'd31, 5'd2, 5'd4, 5'd0, 5'd17, 5'd1
    };

    logic aclk;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_item_t s_item = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_item_t m_item;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    out_item_t rms_due [$];
    logic [SUM_W-1:0] sum_sq [NUM_CH];
    int unsigned sample_cnt [NUM_CH];
    logic [CFG_W-1:0] block_log2;
    logic [1:0] rr_channel = 2'd0;
    int error_count = 0;
    int quiet_cycles = 0;
    int stall_mode = 0;
    int stall_left = 0;

    four_channel_block_rms_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    task automatic flag_mismatch(string what);
        $display("ERROR at %0t: %s", $time, what);
        error_count++;
    endtask

    function automatic in_item_t make_sample(logic [7:0] tag, logic [23:0] value);
        in_item_t it;
        it.word_high = {tag, value[23:16]};
        it.word_low = value[15:0];
        return it;
    endfunction

    function automatic logic [RES_W-1:0] floor_root(logic [SUM_W-1:0] x);
        logic [31:0] r;
        logic [31:0] trial;
        logic [63:0] square;
        r = '0;
        for (int b = 31; b >= 0; b--) begin
            trial = r | (32'd1 << b);
            square = trial * trial;
            if (square <= {1'b0, x}) begin
                r = trial;
            end
        end
        if (r > 32'd8388608) begin
            r = 32'd8388608;
        end
        return r[RES_W-1:0];
    endfunction

    task automatic clear_sums();
        for (int c = 0; c < NUM_CH; c++) begin
            sum_sq[c] = '0;
            sample_cnt[c] = 0;
        end
    endtask

    // Adds one sample to its channel's block and reports whether the block closed.
    task automatic accumulate_sample(in_item_t it, output bit done, output out_item_t rms);
        logic [7:0] tag;
        logic [23:0] raw;
        logic [23:0] mag;
        logic [47:0] sq;
        logic [63:0] total;
        logic [4:0] eff;
        int unsigned target;
        int ch;
        eff = (block_log2 > 5'd16) ? 5'd16 : block_log2;
        target = 1 << eff;
        tag = it.word_high[15:8];
        raw = {it.word_high[7:0], it.word_low};
        rms = '0;
        if (tag[4:0] == 5'd0) begin
            ch = tag[7:5];
            if (ch < NUM_CH && sample_cnt[ch] < target) begin
                mag = raw[23] ? 24'(24'd0 - raw) : raw;
                sq = mag * mag;
                total = {1'b0, sum_sq[ch]} + {16'd0, sq};
                sum_sq[ch] = total[63] ? {SUM_W{1'b1}} : total[SUM_W-1:0];
                sample_cnt[ch]++;
            end
        end
        done = 1'b1;
        for (int c = 0; c < NUM_CH; c++) begin
            if (sample_cnt[c] < target) begin
                done = 1'b0;
            end
        end
        if (done) begin
            for (int c = 0; c < NUM_CH; c++) begin
                rms[c*RES_W +: RES_W] = floor_root(sum_sq[c] >> eff);
            end
            clear_sums();
        end
    endtask

    task automatic send_item(in_item_t it, bit fixed_ok, out_item_t fixed);
        bit done;
        out_item_t rms;
        s_valid <= 1'b1;
        s_item <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        accumulate_sample(it, done, rms);
        if (fixed_ok) begin
            rms_due.push_back(fixed);
        end else if (done) begin
            rms_due.push_back(rms);
        end
        @(negedge aclk);
    endtask

    task automatic apb_transfer(bit wr, logic [PDATA_W-1:0] wdata,
                                output logic [PDATA_W-1:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= BLOCK_LEN_ADDR;
        pwdata <= wdata;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        rdata = prdata;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_block_length(logic [CFG_W-1:0] value);
        logic [PDATA_W-1:0] rd;
        s_valid <= 1'b0;
        while (rms_due.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        apb_transfer(1'b1, PDATA_W'(value), rd);
        block_log2 = value;
        @(negedge aclk);
        apb_transfer(1'b0, '0, rd);
        if (rd !== PDATA_W'(value)) begin
            flag_mismatch($sformatf("block length reads %0d after writing %0d", rd, value));
        end
    endtask

    function automatic in_item_t next_sample();
        logic [7:0] tag;
        logic [23:0] value;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 85) begin
            tag = CHANNEL_TAG[rr_channel];
            rr_channel = rr_channel + 2'd1;
        end else if (pick < 92) begin
            tag = CHANNEL_TAG[$urandom_range(0, NUM_CH - 1)];
        end else begin
            tag = 8'($urandom_range(0, 255));
        end
        case ($urandom_range(0, 7))
            0: value = 24'h800000;
            1: value = 24'h7FFFFF;
            2: value = 24'hFFFFFF;
            3: value = 24'($urandom_range(0, 255));
            default: value = 24'($urandom);
        endcase
        return make_sample(tag, value);
    endfunction

    always @(negedge aclk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_left <= $urandom_range(16, 96);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= 1'($urandom_range(0, 1));
            default: m_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (rms_due.size() == 0) begin
                flag_mismatch("result with no block outstanding");
            end else begin
                want = rms_due.pop_front();
                for (int f = 0; f < NUM_OUT; f++) begin
                    if (m_item[f*RES_W +: RES_W] !== want[f*RES_W +: RES_W]) begin
                        flag_mismatch($sformatf("rms_ch%0d is %0d, expected %0d", f,
                            m_item[f*RES_W +: RES_W], want[f*RES_W +: RES_W]));
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    initial begin
        logic [PDATA_W-1:0] rd;
        int burst;
        int gap;
        int count;
        clear_sums();
        block_log2 = BLOCK_LEN_RESET;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        apb_transfer(1'b0, '0, rd);
        if (rd !== PDATA_W'(BLOCK_LEN_RESET)) begin
            flag_mismatch($sformatf("block length reads %0d after reset", rd));
        end

        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            if (DIRECTED[i].is_cfg) begin
                set_block_length(DIRECTED[i].cfg);
            end else begin
                send_item(make_sample(DIRECTED[i].tag, DIRECTED[i].value),
                          DIRECTED[i].fixed_ok, DIRECTED[i].fixed);
            end
        end

        // Long block lengths get only a partial block; the next phase's shorter
        // length then closes it on its first item.
        for (int p = 0; p < PHASES; p++) begin
            set_block_length(PHASE_LOG2[p]);
            count = (PHASE_LOG2[p] > 5'd8) ? 40 : 130;
            burst = 0;
            for (int n = 0; n < count; n++) begin
                if (burst == 0) begin
                    gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    if (gap > 0) begin
                        s_valid <= 1'b0;
                        repeat (gap) @(negedge aclk);
                    end
                    burst = $urandom_range(1, 24);
                end
                send_item(next_sample(), 1'b0, NO_RMS);
                burst--;
            end
        end

        s_valid <= 1'b0;
        while (rms_due.size() != 0) @(negedge aclk);
        repeat (2 * SETTLE_CYCLES) @(negedge aclk);
        if (error_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
